>>> rtl/core/epc_pkg.sv
// ----------------------------------------------------------------------------
// epc_pkg
// Shared types, codes and constants of the electrode pair health check.
// ----------------------------------------------------------------------------
package epc_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int UV_W       = 24;
    localparam int SUM_W      = UV_W + CNT_W - 1;
    localparam int STEP_W     = $clog2(SUM_W);
    localparam int CNTS_W     = 16;
    localparam int MV_W       = 13;
    localparam int FLAT_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    // action codes
    localparam logic [1:0] ACT_ACC   = 2'd0;
    localparam logic [1:0] ACT_CLOSE = 2'd1;
    localparam logic [1:0] ACT_PROBE = 2'd2;

    // report kinds
    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_GAIN   = 1'b1;

    // verdicts
    localparam logic [1:0] VERD_LIVE      = 2'd0;
    localparam logic [1:0] VERD_OUT_RANGE = 2'd1;
    localparam logic [1:0] VERD_SATURATED = 2'd2;
    localparam logic [1:0] VERD_FLAT      = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COMMON_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMMON_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLAT_THR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_COUNTS = 2'd3;

    localparam logic [MV_W-1:0]   RST_COMMON_MIN = 13'd100;
    localparam logic [MV_W-1:0]   RST_COMMON_MAX = 13'd3200;
    localparam logic [FLAT_W-1:0] RST_FLAT_THR   = 17'd300;
    localparam logic [CNTS_W-1:0] RST_SAT_COUNTS = 16'd32000;

    localparam logic signed [UV_W-1:0] MIN_CLEAR = 24'sh7FFFFF;
    localparam logic signed [UV_W-1:0] MAX_CLEAR = 24'sh800000;

    // half of each gain's full scale, microvolts
    localparam logic [UV_W-1:0] GAIN_HALF_UV [4] = '{
        24'd512000, 24'd1024000, 24'd2048000, 24'd3072000
    };

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [MV_W-1:0]   common_min_mv;
        logic [MV_W-1:0]   common_max_mv;
        logic [FLAT_W-1:0] flat_threshold_uv;
        logic [CNTS_W-1:0] saturation_counts;
    } t_cfg;

    typedef struct packed {
        logic                    kind;
        logic [1:0]              gain;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
        logic signed [UV_W-1:0]  min_uv;
        logic signed [UV_W-1:0]  max_uv;
        logic [CNTS_W-1:0]       peak;
        logic [MV_W-1:0]         pos_mv;
        logic [MV_W-1:0]         neg_mv;
    } t_entry;

endpackage

>>> rtl/core/epc_front.sv
// ----------------------------------------------------------------------------
// epc_front
// Accepts items, keeps the window accumulators and queues closes and probes.
// ----------------------------------------------------------------------------
module epc_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_action,
    input  logic signed [epc_pkg::UV_W-1:0]      i_sample_uv,
    input  logic signed [epc_pkg::CNTS_W-1:0]    i_sample_counts,
    input  logic [epc_pkg::MV_W-1:0]             i_common_pos_mv,
    input  logic [epc_pkg::MV_W-1:0]             i_common_neg_mv,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output epc_pkg::t_entry                      o_entry
);

    logic signed [epc_pkg::UV_W-1:0]  r_min, n_min;
    logic signed [epc_pkg::UV_W-1:0]  r_max, n_max;
    logic signed [epc_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [epc_pkg::CNT_W-1:0]        r_count, n_count;
    logic [epc_pkg::CNTS_W-1:0]       r_peak, n_peak;

    logic                        accept;
    logic                        full;
    logic                        acc;
    logic                        close;
    logic                        probe;
    logic [epc_pkg::CNTS_W-1:0]  mag;
    logic [epc_pkg::UV_W-1:0]    uv_abs;
    logic [1:0]                  gain;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign full    = r_count >= epc_pkg::CNT_W'(epc_pkg::MAX_WINDOW);
    assign close   = accept && (i_action == epc_pkg::ACT_CLOSE);
    assign probe   = accept && (i_action == epc_pkg::ACT_PROBE);
    assign acc     = accept && !full &&
                     (i_action == epc_pkg::ACT_ACC || i_action == epc_pkg::ACT_CLOSE);

    assign mag    = i_sample_counts[epc_pkg::CNTS_W-1] ?
                    epc_pkg::CNTS_W'(-i_sample_counts) : epc_pkg::CNTS_W'(i_sample_counts);
    assign uv_abs = i_sample_uv[epc_pkg::UV_W-1] ?
                    epc_pkg::UV_W'(-i_sample_uv) : epc_pkg::UV_W'(i_sample_uv);

    always_comb begin
        priority if (uv_abs < epc_pkg::GAIN_HALF_UV[0]) begin
            gain = 2'd0;
        end else if (uv_abs < epc_pkg::GAIN_HALF_UV[1]) begin
            gain = 2'd1;
        end else if (uv_abs < epc_pkg::GAIN_HALF_UV[2]) begin
            gain = 2'd2;
        end else begin
            gain = 2'd3;
        end
    end

    always_comb begin
        n_min   = r_min;
        n_max   = r_max;
        n_sum   = r_sum;
        n_count = r_count;
        n_peak  = r_peak;
        if (acc) begin
            if (i_sample_uv < r_min) n_min = i_sample_uv;
            if (i_sample_uv > r_max) n_max = i_sample_uv;
            n_sum   = r_sum + epc_pkg::SUM_W'(i_sample_uv);
            n_count = r_count + 1'b1;
            if (mag > r_peak) n_peak = mag;
        end
    end

    always_comb begin
        o_push         = close || probe;
        o_entry.kind   = probe ? epc_pkg::KIND_GAIN : epc_pkg::KIND_WINDOW;
        o_entry.gain   = gain;
        o_entry.sum    = n_sum;
        o_entry.count  = n_count;
        o_entry.min_uv = n_min;
        o_entry.max_uv = n_max;
        o_entry.peak   = n_peak;
        o_entry.pos_mv = i_common_pos_mv;
        o_entry.neg_mv = i_common_neg_mv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || close) begin
            r_min   <= epc_pkg::MIN_CLEAR;
            r_max   <= epc_pkg::MAX_CLEAR;
            r_sum   <= '0;
            r_count <= '0;
            r_peak  <= '0;
        end else begin
            r_min   <= n_min;
            r_max   <= n_max;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_peak  <= n_peak;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= epc_pkg::CNT_W'(epc_pkg::MAX_WINDOW))
        else $error("window count beyond limit");
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        close |=> (r_count == '0 && r_peak == '0))
        else $error("window not cleared after close");
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && !close) |=> $stable(r_sum))
        else $error("full window accumulated");
`endif

endmodule

>>> rtl/core/epc_queue.sv
// ----------------------------------------------------------------------------
// epc_queue
// Short queue of closes and probes between front and back.
// ----------------------------------------------------------------------------
module epc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  epc_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output epc_pkg::t_entry o_entry
);

    epc_pkg::t_entry                r_mem [epc_pkg::QUEUE_DEPTH];
    logic [epc_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [epc_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [epc_pkg::QCNT_W-1:0]     r_cnt;

    assign o_full  = r_cnt == epc_pkg::QCNT_W'(epc_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue underflow");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= epc_pkg::QCNT_W'(epc_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

>>> rtl/core/epc_back.sv
// ----------------------------------------------------------------------------
// epc_back
// Finishes queued items (window: mean by bit-serial divide, peak-to-peak,
// verdict; probe: gain) and holds the result in the output register.
// ----------------------------------------------------------------------------
module epc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  epc_pkg::t_cfg                     i_cfg,
    input  logic                              i_q_valid,
    input  epc_pkg::t_entry                   i_entry,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_report_kind,
    output logic [1:0]                        o_verdict_code,
    output logic signed [epc_pkg::UV_W-1:0]   o_mean_uv,
    output logic [epc_pkg::UV_W-1:0]          o_peak_to_peak_uv,
    output logic [epc_pkg::CNTS_W-1:0]        o_peak_magnitude,
    output logic [1:0]                        o_gain_index
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                       r_state;
    epc_pkg::t_entry              r_ent;
    logic [epc_pkg::UV_W-1:0]     r_p2p;
    logic [epc_pkg::SUM_W-1:0]    r_dvd;
    logic [epc_pkg::CNT_W-1:0]    r_rem;
    logic [epc_pkg::STEP_W-1:0]   r_step;
    logic                         r_neg;

    logic                         r_out_valid;
    logic                         r_out_kind;
    logic [1:0]                   r_out_verdict;
    logic [epc_pkg::UV_W-1:0]     r_out_mean;
    logic [epc_pkg::UV_W-1:0]     r_out_p2p;
    logic [epc_pkg::CNTS_W-1:0]   r_out_peak;
    logic [1:0]                   r_out_gain;

    logic [epc_pkg::CNT_W:0]      rem_sh;
    logic [epc_pkg::CNT_W:0]      rem_diff;
    logic                         q_bit;
    logic [epc_pkg::UV_W-1:0]     quot;
    logic [epc_pkg::UV_W-1:0]     mean;
    logic [1:0]                   verdict;
    logic                         out_free;
    logic                         out_range;

    assign rem_sh   = {r_rem, r_dvd[epc_pkg::SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_ent.count};
    assign q_bit    = rem_sh >= {1'b0, r_ent.count};
    assign quot     = r_dvd[epc_pkg::UV_W-1:0];
    assign mean     = r_neg ? epc_pkg::UV_W'(-quot) : quot;
    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;

    assign out_range = r_ent.pos_mv < i_cfg.common_min_mv ||
                       r_ent.pos_mv > i_cfg.common_max_mv ||
                       r_ent.neg_mv < i_cfg.common_min_mv ||
                       r_ent.neg_mv > i_cfg.common_max_mv;

    always_comb begin
        priority if (out_range) begin
            verdict = epc_pkg::VERD_OUT_RANGE;
        end else if (r_ent.peak > i_cfg.saturation_counts) begin
            verdict = epc_pkg::VERD_SATURATED;
        end else if (r_p2p < epc_pkg::UV_W'(i_cfg.flat_threshold_uv)) begin
            verdict = epc_pkg::VERD_FLAT;
        end else begin
            verdict = epc_pkg::VERD_LIVE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= (i_entry.kind == epc_pkg::KIND_GAIN) ? ST_DONE : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_step == '0) r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent  <= i_entry;
            r_p2p  <= epc_pkg::UV_W'(i_entry.max_uv - i_entry.min_uv);
            r_neg  <= i_entry.sum[epc_pkg::SUM_W-1];
            r_dvd  <= i_entry.sum[epc_pkg::SUM_W-1] ?
                      epc_pkg::SUM_W'(-i_entry.sum) : epc_pkg::SUM_W'(i_entry.sum);
            r_rem  <= '0;
            r_step <= epc_pkg::STEP_W'(epc_pkg::SUM_W - 1);
        end else if (r_state == ST_DIV) begin
            r_rem  <= q_bit ? rem_diff[epc_pkg::CNT_W-1:0] : rem_sh[epc_pkg::CNT_W-1:0];
            r_dvd  <= {r_dvd[epc_pkg::SUM_W-2:0], q_bit};
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_kind <= r_ent.kind;
            if (r_ent.kind == epc_pkg::KIND_GAIN) begin
                r_out_verdict <= '0;
                r_out_mean    <= '0;
                r_out_p2p     <= '0;
                r_out_peak    <= '0;
                r_out_gain    <= r_ent.gain;
            end else begin
                r_out_verdict <= verdict;
                r_out_mean    <= mean;
                r_out_p2p     <= r_p2p;
                r_out_peak    <= r_ent.peak;
                r_out_gain    <= '0;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_report_kind     = r_out_kind;
    assign o_verdict_code    = r_out_verdict;
    assign o_mean_uv         = r_out_mean;
    assign o_peak_to_peak_uv = r_out_p2p;
    assign o_peak_magnitude  = r_out_peak;
    assign o_gain_index      = r_out_gain;

`ifndef ASSERT_OFF
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_ent.count != '0))
        else $error("divide by zero count");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_DIV || r_state == ST_DONE))
        else $error("pop did not start work");
    a_gain_skips_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_ent.kind == epc_pkg::KIND_WINDOW))
        else $error("probe entered divider");
`endif

endmodule

>>> rtl/core/electrode_pair_health_check_top.sv
// ----------------------------------------------------------------------------
// electrode_pair_health_check_top
// Window statistics and health verdict for one differential electrode pair.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                        Contents
// s_axis    in   tvalid/tready/tdata/tuser      sample or probe item
// m_axis    out  tvalid/tready/tdata/tuser      window report or gain choice
// cfg       in   i_cfg_we/i_cfg_idx/i_cfg_data  register writes
//
// Accumulate items stay in the front end. A close occupies the back end for
// one load, 29 bit-serial divide steps and a result state that waits for a
// free output register; a probe skips the divide. Synchronous active-low
// reset; no clearing pass. Input stalls only when the two-entry queue is full.
// ----------------------------------------------------------------------------
module electrode_pair_health_check_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // sample_uv[23:0], sample_counts[39:24], common_pos_mv[52:40],
    // common_neg_mv[65:53], zero pad
    input  logic [epc_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // action[1:0]
    input  logic [1:0]                          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // verdict_code[1:0], mean_uv[25:2], peak_to_peak_uv[49:26],
    // peak_magnitude[65:50], gain_index[67:66], zero pad
    output logic [epc_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // report_kind[0]
    output logic                                o_m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [epc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [epc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    epc_pkg::t_cfg   r_cfg;
    epc_pkg::t_entry push_entry;
    epc_pkg::t_entry head_entry;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_valid;

    logic                              out_kind;
    logic [1:0]                        out_verdict;
    logic signed [epc_pkg::UV_W-1:0]   out_mean;
    logic [epc_pkg::UV_W-1:0]          out_p2p;
    logic [epc_pkg::CNTS_W-1:0]        out_peak;
    logic [1:0]                        out_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.common_min_mv     <= epc_pkg::RST_COMMON_MIN;
            r_cfg.common_max_mv     <= epc_pkg::RST_COMMON_MAX;
            r_cfg.flat_threshold_uv <= epc_pkg::RST_FLAT_THR;
            r_cfg.saturation_counts <= epc_pkg::RST_SAT_COUNTS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                epc_pkg::REG_COMMON_MIN: r_cfg.common_min_mv     <= i_cfg_data[12:0];
                epc_pkg::REG_COMMON_MAX: r_cfg.common_max_mv     <= i_cfg_data[12:0];
                epc_pkg::REG_FLAT_THR:   r_cfg.flat_threshold_uv <= i_cfg_data[16:0];
                epc_pkg::REG_SAT_COUNTS: r_cfg.saturation_counts <= i_cfg_data[15:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    epc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_action        (i_s_axis_tuser),
        .i_sample_uv     (i_s_axis_tdata[23:0]),
        .i_sample_counts (i_s_axis_tdata[39:24]),
        .i_common_pos_mv (i_s_axis_tdata[52:40]),
        .i_common_neg_mv (i_s_axis_tdata[65:53]),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    epc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    epc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_q_valid         (q_valid),
        .i_entry           (head_entry),
        .o_pop             (pop),
        .o_valid           (o_m_axis_tvalid),
        .i_ready           (i_m_axis_tready),
        .o_report_kind     (out_kind),
        .o_verdict_code    (out_verdict),
        .o_mean_uv         (out_mean),
        .o_peak_to_peak_uv (out_p2p),
        .o_peak_magnitude  (out_peak),
        .o_gain_index      (out_gain)
    );

    assign o_m_axis_tuser = out_kind;
    assign o_m_axis_tdata = {4'b0, out_gain, out_peak, out_p2p, out_mean, out_verdict};

endmodule
